// ===== src/ssr_pkg.sv =====
// Shared types, constants and the sector map for the phase current rebuild block.
// No dependencies; used by every module under src.
`default_nettype none
package ssr_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam logic [15:0] SAMPLE_MASK = 16'((32'd1 << SAMPLE_BITS) - 32'd1);

    localparam int          FILTER_SHIFT = 8;
    localparam logic [8:0]  FILTER_ONE   = 9'(1 << FILTER_SHIFT);
    localparam logic [8:0]  ALPHA_RESET  = 9'd64;

    // ADC command ids
    localparam logic [3:0] ID_CUR0  = 4'd1;
    localparam logic [3:0] ID_CUR1  = 4'd2;
    localparam logic [3:0] ID_CUR2  = 4'd3;
    localparam logic [3:0] ID_COND  = 4'd4;
    localparam logic [3:0] ID_AMB   = 4'd5;
    localparam logic [3:0] ID_DIS   = 4'd6;
    localparam logic [3:0] ID_HEAT  = 4'd7;

    localparam logic OP_ADC     = 1'b0;
    localparam logic OP_REBUILD = 1'b1;

    localparam int          PADDR_BITS = 3;
    localparam logic [0:0]  REG_ALPHA  = 1'b0;

    typedef struct packed {
        logic        operation;
        logic [3:0]  command_id;
        logic [15:0] conv_value;
        logic [2:0]  sector;
    } t_in;

    typedef struct packed {
        logic signed [15:0] phase_a;
        logic signed [15:0] phase_b;
        logic signed [15:0] phase_c;
        logic [15:0]        ambient_filtered;
        logic [15:0]        discharge_filtered;
        logic [15:0]        condenser_raw;
        logic [15:0]        heatsink_raw;
    } t_res;

    typedef enum logic [2:0] {
        K_NOP  = 3'd0,
        K_CUR  = 3'd1,
        K_COND = 3'd2,
        K_AMB  = 3'd3,
        K_DIS  = 3'd4,
        K_HEAT = 3'd5,
        K_REB  = 3'd6
    } t_kind;

    // phase index receiving first, second and remaining value
    typedef struct packed {
        logic [1:0] first;
        logic [1:0] second;
        logic [1:0] rest;
    } t_map;

    typedef struct packed {
        t_kind       kind;
        logic [1:0]  sel;     // current sample slot
        logic [15:0] value;
        t_map        map;
    } t_cmd;

    function automatic t_map sector_map(input logic [2:0] sector);
        t_map m;
        m = '0;
        unique case (sector)
            3'd1:    m = '{first: 2'd0, second: 2'd2, rest: 2'd1};
            3'd2:    m = '{first: 2'd1, second: 2'd2, rest: 2'd0};
            3'd3:    m = '{first: 2'd1, second: 2'd0, rest: 2'd2};
            3'd4:    m = '{first: 2'd2, second: 2'd0, rest: 2'd1};
            3'd5:    m = '{first: 2'd2, second: 2'd1, rest: 2'd0};
            3'd6:    m = '{first: 2'd0, second: 2'd1, rest: 2'd2};
            default: m = '0;
        endcase
        return m;
    endfunction

endpackage
`default_nettype wire

// ===== src/ssr_front.sv =====
// Front end: takes input words and turns them into decoded commands for the queue.
// Depends on ssr_pkg.
`default_nettype none
module ssr_front
    import ssr_pkg::*;
(
    input  wire  i_valid,
    input  t_in  i_item,
    input  wire  i_full,
    output logic o_stall,
    output logic o_push,
    output t_cmd o_cmd
);

    logic [15:0] value;

    assign value   = i_item.conv_value & SAMPLE_MASK;
    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full;

    always_comb begin
        o_cmd       = '0;
        o_cmd.kind  = K_NOP;
        o_cmd.value = value;
        o_cmd.map   = sector_map(i_item.sector);
        if (i_item.operation == OP_REBUILD) begin
            // sectors 0 and 7 leave the currents alone
            if (i_item.sector != 3'd0 && i_item.sector != 3'd7) begin
                o_cmd.kind = K_REB;
            end
        end else begin
            unique case (i_item.command_id)
                ID_CUR0: begin o_cmd.kind = K_CUR; o_cmd.sel = 2'd0; end
                ID_CUR1: begin o_cmd.kind = K_CUR; o_cmd.sel = 2'd1; end
                ID_CUR2: begin o_cmd.kind = K_CUR; o_cmd.sel = 2'd2; end
                ID_COND: o_cmd.kind = K_COND;
                ID_AMB:  o_cmd.kind = K_AMB;
                ID_DIS:  o_cmd.kind = K_DIS;
                ID_HEAT: o_cmd.kind = K_HEAT;
                default: o_cmd.kind = K_NOP;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== src/ssr_queue.sv =====
// Two-entry command queue between front and back end.
// Depends on ssr_pkg.
`default_nettype none
module ssr_queue
    import ssr_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_push,
    input  t_cmd i_cmd,
    input  wire  i_pop,
    output logic o_full,
    output logic o_empty,
    output t_cmd o_cmd
);

    t_cmd       r_mem [2];
    logic       r_wptr, r_rptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_cmd   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
            priority if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule
`default_nettype wire

// ===== src/ssr_back.sv =====
// Back end: executes queued commands on the sample/current/temperature state
// and holds the output word register. Depends on ssr_pkg.
`default_nettype none
module ssr_back
    import ssr_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire  [8:0] i_alpha,
    input  wire        i_empty,
    input  t_cmd       i_cmd,
    output logic       o_pop,
    input  wire        i_stall,
    output logic       o_valid,
    output t_res       o_result
);

    logic [15:0] r_samp [3];
    logic [15:0] r_phase [3];
    logic [15:0] r_amb, r_dis, r_cond, r_heat;
    logic        r_valid;
    t_res        r_res;

    logic [15:0] n_samp [3];
    logic [15:0] n_phase [3];
    logic [15:0] n_amb, n_dis, n_cond, n_heat;

    logic [8:0]  alpha;
    logic [15:0] iir_old;
    logic [24:0] acc;
    logic [15:0] iir_new;
    logic [15:0] first, second, rest;

    assign o_pop    = !i_empty && (!r_valid || !i_stall);
    assign o_valid  = r_valid;
    assign o_result = r_res;

    // single IIR datapath shared by both temperature channels
    assign alpha   = (i_alpha > FILTER_ONE) ? FILTER_ONE : i_alpha;
    assign iir_old = (i_cmd.kind == K_DIS) ? r_dis : r_amb;
    assign acc     = (25'(alpha) * 25'(i_cmd.value))
                   + (25'(FILTER_ONE - alpha) * 25'(iir_old));
    assign iir_new = acc[FILTER_SHIFT +: 16];

    assign first  = r_samp[2] - r_samp[0];
    assign second = r_samp[1] - r_samp[2];
    assign rest   = r_samp[0] - r_samp[1];

    always_comb begin
        n_samp  = r_samp;
        n_phase = r_phase;
        n_amb   = r_amb;
        n_dis   = r_dis;
        n_cond  = r_cond;
        n_heat  = r_heat;
        unique case (i_cmd.kind)
            K_CUR:  n_samp[i_cmd.sel] = i_cmd.value;
            K_COND: n_cond = i_cmd.value;
            K_AMB:  n_amb = iir_new;
            K_DIS:  n_dis = iir_new;
            K_HEAT: n_heat = i_cmd.value;
            K_REB: begin
                n_phase[i_cmd.map.first]  = first;
                n_phase[i_cmd.map.second] = second;
                n_phase[i_cmd.map.rest]   = rest;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_samp  <= '{default: '0};
            r_phase <= '{default: '0};
            r_amb   <= '0;
            r_dis   <= '0;
            r_cond  <= '0;
            r_heat  <= '0;
        end else begin
            if (o_pop) begin
                r_valid <= 1'b1;
                r_samp  <= n_samp;
                r_phase <= n_phase;
                r_amb   <= n_amb;
                r_dis   <= n_dis;
                r_cond  <= n_cond;
                r_heat  <= n_heat;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_res.phase_a            <= n_phase[0];
            r_res.phase_b            <= n_phase[1];
            r_res.phase_c            <= n_phase[2];
            r_res.ambient_filtered   <= n_amb;
            r_res.discharge_filtered <= n_dis;
            r_res.condenser_raw      <= n_cond;
            r_res.heatsink_raw       <= n_heat;
        end
    end

endmodule
`default_nettype wire

// ===== src/single_shunt_phase_current_rebuild_top.sv =====
// From input accept to result valid: the accept edge writes the queue, and the back end
// then executes from the queue into the output register. Throughput: one word per cycle
// while the result side does not stall, set by the single execute stage. Reset (i_rst_n
// low, synchronous): queue and output emptied, all state zero, alpha 64.
// Depends on ssr_pkg, ssr_front, ssr_queue, ssr_back.
`default_nettype none
module single_shunt_phase_current_rebuild_top
    import ssr_pkg::*;
(
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    // input word channel
    input  wire                  i_valid,
    output logic                 o_stall,
    input  t_in                  i_item,
    // result word channel
    output logic                 o_valid,
    input  wire                  i_stall,
    output t_res                 o_result,
    // APB register port
    input  wire                  psel,
    input  wire                  penable,
    input  wire                  pwrite,
    input  wire [PADDR_BITS-1:0] paddr,
    input  wire [31:0]           pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    // Front decodes the word (command id or sector) into a command; the queue
    // decouples it from the back end, which owns all state and the output register.

    logic [8:0] r_alpha;
    logic       full, empty, push, pop;
    t_cmd       front_cmd, queue_cmd;
    logic       reg_wr;

    // alpha register, APB access with no wait states; only register 0 exists
    assign pready = 1'b1;
    assign reg_wr = psel && penable && pwrite;
    assign prdata = (paddr[PADDR_BITS-1] == REG_ALPHA) ? {23'd0, r_alpha} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha <= ALPHA_RESET;
        end else if (reg_wr && paddr[PADDR_BITS-1] == REG_ALPHA) begin
            r_alpha <= pwdata[8:0];
        end
    end

    ssr_front u_front (
        .i_valid (i_valid),
        .i_item  (i_item),
        .i_full  (full),
        .o_stall (o_stall),
        .o_push  (push),
        .o_cmd   (front_cmd)
    );

    // two entries sustain one word per cycle without a pop-to-push path, while the result side does not stall
    ssr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_cmd   (queue_cmd)
    );

    ssr_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_alpha  (r_alpha),
        .i_empty  (empty),
        .i_cmd    (queue_cmd),
        .o_pop    (pop),
        .i_stall  (i_stall),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

endmodule
`default_nettype wire

// ===== bench/single_shunt_rebuild_checker.sv =====
// Checker for the single-shunt phase current rebuild block: watches both word channels
// and the APB port, predicts every result word and compares it field by field.
// Depends on ssr_pkg.
module single_shunt_rebuild_checker
    import ssr_pkg::*;
(
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    input  wire                  i_in_stall,
    input  t_in                  i_in_word,
    input  wire                  i_out_valid,
    input  wire                  i_out_stall,
    input  t_res                 i_out_word,
    input  wire                  i_psel,
    input  wire                  i_penable,
    input  wire                  i_pwrite,
    input  wire [PADDR_BITS-1:0] i_paddr,
    input  wire [31:0]           i_pwdata,
    input  wire [31:0]           i_prdata,
    input  wire                  i_pready,
    output int                   o_fail_count,
    output int                   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [15:0] shunt_sample [3];
    logic [15:0] phase_current [3];
    logic [15:0] ambient_level;
    logic [15:0] discharge_level;
    logic [15:0] condenser_sample;
    logic [15:0] heatsink_sample;
    logic [8:0]  alpha;
    t_res        expected_results [$];
    t_res        want;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic logic [15:0] iir_step(input logic [15:0] old, input logic [15:0] raw,
                                            input logic [8:0] weight);
        logic [31:0] a;
        logic [31:0] acc;
        a   = (weight > FILTER_ONE) ? 32'(FILTER_ONE) : 32'(weight);
        acc = a * 32'(raw) + (32'(FILTER_ONE) - a) * 32'(old);
        acc = acc >> FILTER_SHIFT;
        return acc[15:0];
    endfunction

    task automatic note_failure(input string what, input logic [31:0] exp_v,
                                input logic [31:0] act_v);
        o_fail_count++;
        if (o_fail_count <= 10)
            $display("%0t: mismatch on %s: expected %h, got %h", $time, what, exp_v, act_v);
    endtask

    task automatic check_field(input string what, input logic [15:0] exp_v,
                               input logic [15:0] act_v);
        if (act_v !== exp_v)
            note_failure(what, 32'(exp_v), 32'(act_v));
    endtask

    // Update the sample state for one accepted word and queue the result it yields.
    task automatic predict_rebuild_word(input t_in w);
        logic [15:0] v;
        logic [15:0] first;
        logic [15:0] second;
        logic [15:0] rest;
        int          fi;
        int          si;
        int          ri;
        v  = w.conv_value & SAMPLE_MASK;
        fi = -1;
        si = 0;
        ri = 0;
        if (w.operation == OP_ADC) begin
            case (w.command_id)
                ID_CUR0: shunt_sample[0] = v;
                ID_CUR1: shunt_sample[1] = v;
                ID_CUR2: shunt_sample[2] = v;
                ID_COND: condenser_sample = v;
                ID_AMB:  ambient_level = iir_step(ambient_level, v, alpha);
                ID_DIS:  discharge_level = iir_step(discharge_level, v, alpha);
                ID_HEAT: heatsink_sample = v;
                default: ;
            endcase
        end else begin
            first  = shunt_sample[2] - shunt_sample[0];
            second = shunt_sample[1] - shunt_sample[2];
            rest   = 16'd0 - 16'(first + second);
            case (w.sector)
                3'd1: begin fi = 0; si = 2; ri = 1; end
                3'd2: begin fi = 1; si = 2; ri = 0; end
                3'd3: begin fi = 1; si = 0; ri = 2; end
                3'd4: begin fi = 2; si = 0; ri = 1; end
                3'd5: begin fi = 2; si = 1; ri = 0; end
                3'd6: begin fi = 0; si = 1; ri = 2; end
                default: fi = -1;
            endcase
            if (fi >= 0) begin
                phase_current[fi] = first;
                phase_current[si] = second;
                phase_current[ri] = rest;
            end
        end
        expected_results.push_back('{phase_a: phase_current[0],
                                     phase_b: phase_current[1],
                                     phase_c: phase_current[2],
                                     ambient_filtered: ambient_level,
                                     discharge_filtered: discharge_level,
                                     condenser_raw: condenser_sample,
                                     heatsink_raw: heatsink_sample});
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                shunt_sample[k]  = '0;
                phase_current[k] = '0;
            end
            ambient_level    = '0;
            discharge_level  = '0;
            condenser_sample = '0;
            heatsink_sample  = '0;
            alpha            = ALPHA_RESET;
            expected_results.delete();
        end else begin
            // result side first: a word cannot come out in the cycle it goes in
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    note_failure("unexpected result word", '0,
                                 32'(i_out_word.heatsink_raw));
                end else begin
                    want = expected_results.pop_front();
                    check_field("phase_a", want.phase_a, i_out_word.phase_a);
                    check_field("phase_b", want.phase_b, i_out_word.phase_b);
                    check_field("phase_c", want.phase_c, i_out_word.phase_c);
                    check_field("ambient_filtered", want.ambient_filtered,
                                i_out_word.ambient_filtered);
                    check_field("discharge_filtered", want.discharge_filtered,
                                i_out_word.discharge_filtered);
                    check_field("condenser_raw", want.condenser_raw, i_out_word.condenser_raw);
                    check_field("heatsink_raw", want.heatsink_raw, i_out_word.heatsink_raw);
                end
            end
            if (i_in_valid && !i_in_stall)
                predict_rebuild_word(i_in_word);
            if (i_psel && i_penable && i_pready && (i_paddr >> 2) == REG_ALPHA) begin
                if (i_pwrite)
                    alpha = i_pwdata[8:0];
                else if (i_prdata !== 32'(alpha))
                    note_failure("filter_alpha readback", 32'(alpha), i_prdata);
            end
        end
        o_pending = expected_results.size();
    end

endmodule

// ===== bench/single_shunt_phase_current_rebuild_top_tb.sv =====
// Top of the phase current rebuild bench: clock, reset, word and APB stimulus, verdict.
// Depends on ssr_pkg, single_shunt_rebuild_checker and the block under src.
module single_shunt_phase_current_rebuild_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ssr_pkg::*;

    localparam int IDLE_PCT       = 6;     // idle / stall chance per cycle, in percent
    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no handshake before giving up
    localparam int RANDOM_WORDS   = 1650;
    localparam int PHASES         = 7;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    wire                   in_stall;
    t_in                   in_word;
    wire                   out_valid;
    logic                  out_stall;
    t_res                  out_word;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [PADDR_BITS-1:0] paddr;
    logic [31:0]           pwdata;
    wire  [31:0]           prdata;
    wire                   pready;

    int   fail_count;
    int   pending;
    int   live_words;     // rebuild words and words with a known id; ignored ids are not counted
    int   idle_cycles;
    logic no_idle;        // set for the gap-free stretch

    single_shunt_phase_current_rebuild_top uut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_valid  (in_valid),
        .o_stall  (in_stall),
        .i_item   (in_word),
        .o_valid  (out_valid),
        .i_stall  (out_stall),
        .o_result (out_word),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    single_shunt_rebuild_checker checker_i (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_word    (in_word),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_word   (out_word),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_prdata     (prdata),
        .i_pready     (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Result side: random stalls, none during the gap-free stretch.
    always @(negedge clk) begin
        out_stall <= !no_idle && ($urandom_range(99) < IDLE_PCT);
    end

    // Watchdog: any accepted word or APB access counts as progress.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Raw ADC value, biased toward the corners so wraps and full-scale filter steps show up.
    function automatic logic [15:0] rand_sample();
        case ($urandom_range(15))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h8000;
            3:       return 16'h7FFF;
            default: return 16'($urandom_range(16'hFFFF));
        endcase
    endfunction

    function automatic t_in make_word(input logic op, input logic [3:0] id,
                                      input logic [15:0] value, input logic [2:0] sector);
        t_in w;
        w.operation  = op;
        w.command_id = id;
        w.conv_value = value;
        w.sector     = sector;
        return w;
    endfunction

    // ADC word; the sector field is don't-care and gets noise.
    function automatic t_in adc_word(input logic [3:0] id, input logic [15:0] value);
        return make_word(OP_ADC, id, value, 3'($urandom_range(7)));
    endfunction

    // Rebuild request; id and value fields are don't-care and get noise.
    function automatic t_in rebuild_word(input logic [2:0] sector);
        return make_word(OP_REBUILD, 4'($urandom_range(15)), rand_sample(), sector);
    endfunction

    // Called at a falling edge; returns at the falling edge after the word is taken.
    // Valid is only raised once per step, so back-to-back words keep it high.
    task automatic send_word(input t_in w);
        while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        if (w.operation == OP_REBUILD || (w.command_id >= ID_CUR0 && w.command_id <= ID_HEAT))
            live_words++;
        @(negedge clk);
    endtask

    // APB access, setup phase then access phase; starts and ends at a falling edge.
    task automatic apb_access(input logic wr, input logic [PADDR_BITS-1:0] addr,
                              input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Hold the sender until every predicted word is out, then let the pipe (queue and
    // output register) settle before any register traffic.
    task automatic drain_block();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    initial begin
        int alpha_plan [PHASES];
        int target;
        int start;
        int step;

        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_word    = '0;
        out_stall  = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        no_idle    = 1'b0;
        live_words = 0;
        idle_cycles = 0;

        // first phase runs on the reset weight; 511 checks the saturation at 256
        alpha_plan = '{-1, 0, 256, 511, 1, 255, 0};
        alpha_plan[PHASES-1] = $urandom_range(2, 510);

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset value of the weight must read back as 64
        apb_access(1'b0, PADDR_BITS'(REG_ALPHA) << 2, '0);

        // ---- directed part ----
        send_word(rebuild_word(3'd1));                  // all-zero state
        send_word(adc_word(ID_CUR0, 16'hFFFF));
        send_word(adc_word(ID_CUR1, 16'h0000));
        send_word(adc_word(ID_CUR2, 16'h8000));         // forces 16-bit wrap in the rebuild
        for (int s = 0; s < 8; s++)                     // every sector plus both no-op codes
            send_word(rebuild_word(3'(s)));
        send_word(adc_word(ID_COND, 16'hFFFF));
        send_word(adc_word(ID_HEAT, 16'hFFFF));
        send_word(adc_word(ID_AMB, 16'hFFFF));
        send_word(adc_word(ID_AMB, 16'hFFFF));
        send_word(adc_word(ID_DIS, 16'hFFFF));
        send_word(adc_word(ID_DIS, 16'h0000));
        send_word(adc_word(ID_AMB, 16'h0000));
        send_word(adc_word(ID_COND, 16'h0000));
        // unknown ids must leave everything alone
        send_word(adc_word(4'd0, 16'hFFFF));
        send_word(adc_word(ID_HEAT + 4'd1, 16'hFFFF));
        send_word(adc_word(4'hF, 16'hFFFF));
        live_words = 0;

        // ---- random part, one block per weight setting ----
        target = RANDOM_WORDS / PHASES;
        for (int p = 0; p < PHASES; p++) begin
            if (alpha_plan[p] >= 0) begin
                drain_block();
                apb_access(1'b1, PADDR_BITS'(REG_ALPHA) << 2, 32'(alpha_plan[p]));
                if (p == 1)  // a write above the register map must not touch the weight
                    apb_access(1'b1, (PADDR_BITS'(REG_ALPHA) + PADDR_BITS'(1)) << 2,
                               32'h1AB);
                apb_access(1'b0, PADDR_BITS'(REG_ALPHA) << 2, '0);
            end
            no_idle    = (p == 3);      // gap-free stretch on both sides
            live_words = 0;
            while (live_words < target) begin
                if ($urandom_range(99) < 75) begin
                    // well-formed: three shunt samples in a random order, at times another ADC word, then a rebuild
                    start = $urandom_range(2);
                    step  = $urandom_range(1) ? 1 : 2;
                    for (int k = 0; k < 3; k++)
                        send_word(adc_word(4'(ID_CUR0 + 4'((start + k * step) % 3)),
                                           rand_sample()));
                    if ($urandom_range(3) == 0)
                        send_word(adc_word(4'(ID_COND + 4'($urandom_range(3))), rand_sample()));
                    send_word(rebuild_word($urandom_range(9) == 0 ? 3'($urandom_range(1) * 7)
                                                                  : 3'($urandom_range(1, 6))));
                    if ($urandom_range(2) == 0)
                        send_word(rebuild_word(3'($urandom_range(7))));
                end else begin
                    // noise: any field combination, unknown ids included
                    send_word(make_word(1'($urandom_range(1)), 4'($urandom_range(15)),
                                        rand_sample(), 3'($urandom_range(7))));
                end
            end
            no_idle = 1'b0;
        end

        // ---- wind down ----
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (pending != 0)
            $display("%0d result words never arrived", pending);
        if (fail_count == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
